### hw/rtl/fq_pkg.sv
// fq_pkg: action and status codes, cell control types for the tag queue.
// No dependencies; imported by fq_cell, fifo_queue_with_cancel and the testbench.
package fq_pkg;

    localparam int IO_TAG_W = 32;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_REMOVE  = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_INIT = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NO_ITEM  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_SHIFT  = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_LOAD   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     live;
        logic     tail;
    } cell_ctl_t;

endpackage

### hw/rtl/fq_cell.sv
// fq_cell: one queue slot; holds a tag, compares it to the search key and
// takes its neighbor's tag when the gap closes. Depends on fq_pkg.
module fq_cell #(
    parameter int TW = 32
) (
    input  logic              clk,
    input  fq_pkg::cell_ctl_t ctl,
    input  logic [TW-1:0]     key,
    input  logic [TW-1:0]     nbr_tag,
    input  logic              hit_in,
    output logic              hit_out,
    output logic [TW-1:0]     tag
);
    import fq_pkg::*;

    logic [TW-1:0] tag_reg;
    logic [TW-1:0] tag_next;
    logic          match;

    assign match   = ctl.live && (tag_reg == key);
    assign hit_out = hit_in || match;
    assign tag     = tag_reg;

    always_comb
    begin
        tag_next = tag_reg;
        case (ctl.op)
            CELL_SHIFT:  tag_next = nbr_tag;
            CELL_REMOVE: if (hit_out) tag_next = nbr_tag;
            CELL_LOAD:   if (ctl.tail) tag_next = key;
            default:     tag_next = tag_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule

### hw/rtl/fifo_queue_with_cancel.sv
// fifo_queue_with_cancel: order-keeping tag queue on a chain of DEPTH cells.
// Results: a transaction's result is registered when it is accepted.
// Throughput: one action per cycle while out_ready is high; the search hit ripples through the cell chain.
// Reset: occupancy, enable, and output valid clear; stored tags, status and head are not reset.
// Depends on fq_pkg and fq_cell.
module fifo_queue_with_cancel #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 32,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [fq_pkg::IO_TAG_W-1:0] item_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [fq_pkg::IO_TAG_W-1:0] head_tag,
    output logic [CW-1:0]               occupancy
);
    import fq_pkg::*;

    // Tags narrower than the port carry zeros above them; store only real bits.
    localparam int TW = (TAG_WIDTH < IO_TAG_W) ? TAG_WIDTH : IO_TAG_W;

    logic                enabled_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [IO_TAG_W-1:0] head_reg, head_next;

    logic                accept;
    action_t             act;
    cell_op_t            op;
    logic [TW-1:0]       key;
    logic [TW-1:0]       tags [DEPTH];
    logic [DEPTH:0]      hit;
    logic                full, empty;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign act       = action_t'(action);
    assign key       = item_tag[TW-1:0];
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign head_tag  = head_reg;
    assign occupancy = count_reg;

    // Decode the transaction into one command broadcast along the chain.
    always_comb
    begin
        op          = CELL_HOLD;
        count_next  = count_reg;
        status_next = ST_OK;
        head_next   = '0;
        if (!enabled_reg)
        begin
            status_next = ST_NOT_INIT;
        end
        else
        begin
            unique case (act)
                ACT_ENQUEUE:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        op         = CELL_LOAD;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_DEQUEUE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        op         = CELL_SHIFT;
                        head_next  = IO_TAG_W'(tags[0]);
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    // First hit and every cell behind it close the gap.
                    op = CELL_REMOVE;
                    if (hit[DEPTH])
                        count_next = count_reg - 1'b1;
                    else
                        status_next = ST_NO_ITEM;
                end
                ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_ctl_t     ctl;
            logic [TW-1:0] nbr;

            assign ctl.op   = accept ? op : CELL_HOLD;
            assign ctl.live = (count_reg > CW'(gi));
            assign ctl.tail = (count_reg == CW'(gi));

            if (gi == DEPTH - 1)
            begin : g_last
                assign nbr = tags[gi];
            end
            else
            begin : g_mid
                assign nbr = tags[gi + 1];
            end

            fq_cell #(
                .TW(TW)
            ) u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .key     (key),
                .nbr_tag (nbr),
                .hit_in  (hit[gi]),
                .hit_out (hit[gi + 1]),
                .tag     (tags[gi])
            );
        end
    endgenerate

    // Hold control state; advance occupancy and result on each transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                enabled_reg <= cfg_wdata;
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            head_reg   <= head_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && enabled_reg && act == ACT_ENQUEUE && full
        |=> status_reg == ST_FULL && $stable(count_reg))
        else $error("enqueue into full queue not flagged");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && enabled_reg && act == ACT_DEQUEUE && !empty
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not drop occupancy");

    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !enabled_reg |=> status_reg == ST_NOT_INIT && $stable(count_reg))
        else $error("action taken while disabled");

endmodule

### verif/tb_fifo_queue_with_cancel.sv
// tb_fifo_queue_with_cancel: self-checking testbench for the tag queue with remove by value.
// Holds its own queue model as the predictor, plus a directed table and random traffic.
// Depends on fq_pkg and fifo_queue_with_cancel.
module tb_fifo_queue_with_cancel;
    timeunit 1ns;
    timeprecision 1ps;

    import fq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    // Long receiver hold-off, long enough for the sender to back up behind it.
    localparam int LONG_HOLD   = 60;
    // Rows of the directed table that run with the queue still disabled.
    localparam int OFF_ROWS    = 3;

    // One expected or observed result transaction.
    typedef struct packed {
        status_t            status;
        logic [IO_TAG_W-1:0] head;
        logic [OCC_W-1:0]    occ;
    } qres_t;

    // One row of the directed table; typed rows carry their result, the rest use the model.
    typedef struct {
        action_t             act;
        logic [IO_TAG_W-1:0] tag;
        bit                  typed;
        qres_t               want;
    } step_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [1:0]          action    = '0;
    logic [IO_TAG_W-1:0] item_tag  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2:0]          status;
    logic [IO_TAG_W-1:0] head_tag;
    logic [OCC_W-1:0]    occupancy;

    // Predictor state: held tags with the head at index 0, and the enable register.
    logic [IO_TAG_W-1:0] held_tags[$];
    bit                  queue_on;

    qres_t     pending_results[$];
    step_row_t dir_rows[$];

    // Side channel from the sender to the monitor for typed directed rows.
    bit    row_typed;
    qres_t row_want;
    qres_t got_res;
    qres_t want_res;

    // Knobs for idling; idle_on is cleared for the last part of the run.
    bit idle_on       = 1'b1;
    int gap_pct       = 25;
    int stall_pct     = 25;
    bit long_hold_req = 1'b0;

    int error_count;
    int accepted_count;
    int checked_count;
    int full_stalls;
    int status_seen[8];
    int cycle_count;

    fifo_queue_with_cancel #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (IO_TAG_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .item_tag  (item_tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .head_tag  (head_tag),
        .occupancy (occupancy)
    );

    always #5 clk = ~clk;

    // Advance the predictor by one action and return the result it causes.
    function automatic qres_t apply_action(input action_t act, input logic [IO_TAG_W-1:0] tag);
        qres_t r;
        r        = '0;
        r.status = ST_OK;
        if (!queue_on) begin
            r.status = ST_NOT_INIT;
        end
        else begin
            case (act)
                ACT_ENQUEUE:
                begin
                    if (held_tags.size() >= DEPTH)
                        r.status = ST_FULL;
                    else
                        held_tags.push_back(tag);
                end
                ACT_DEQUEUE:
                begin
                    if (held_tags.size() == 0)
                        r.status = ST_EMPTY;
                    else
                        r.head = held_tags.pop_front();
                end
                ACT_REMOVE:
                begin
                    // Search from the head; only the first match goes, the rest close up.
                    r.status = ST_NO_ITEM;
                    foreach (held_tags[i]) begin
                        if (r.status == ST_NO_ITEM && held_tags[i] == tag) begin
                            held_tags.delete(i);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                default:
                begin
                    held_tags.delete();
                end
            endcase
        end
        r.occ = OCC_W'(held_tags.size());
        return r;
    endfunction

    // Monitor: sample both handshakes at the rising edge, check results, queue predictions.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we)
                queue_on = cfg_wdata;

            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing expected: status %0d head %h occ %0d",
                             $time, status, head_tag, occupancy);
                end
                else begin
                    want_res = pending_results.pop_front();
                    checked_count++;
                    status_seen[want_res.status]++;
                    if (status !== want_res.status) begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want_res.status, status);
                    end
                    if (head_tag !== want_res.head) begin
                        error_count++;
                        $display("%0t: head_tag expected %h actual %h",
                                 $time, want_res.head, head_tag);
                    end
                    if (occupancy !== want_res.occ) begin
                        error_count++;
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want_res.occ, occupancy);
                    end
                end
            end

            if (in_valid && !in_ready)
                full_stalls++;

            if (in_valid && in_ready) begin
                // The model always advances, so typed rows keep it in step too.
                got_res = apply_action(action_t'(action), item_tag);
                if (row_typed)
                    got_res = row_want;
                pending_results.push_back(got_res);
                accepted_count++;
            end
        end
    end

    // Watchdog: end the run if the traffic never drains.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("[fifo_queue_with_cancel] ERROR");
            $finish;
        end
    end

    // Receiver: at most one assignment to out_ready per falling edge; random stall bursts,
    // and a long hold-off on request, counted here in cycles.
    initial begin : receiver
        int hold_cnt;
        int burst;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                for (hold_cnt = 1; hold_cnt < LONG_HOLD; hold_cnt++)
                    @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
                burst = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic add_row(input action_t act, input logic [IO_TAG_W-1:0] tag, input bit typed,
                           input status_t st, input logic [IO_TAG_W-1:0] head,
                           input int occ);
        step_row_t r;
        r.act         = act;
        r.tag         = tag;
        r.typed       = typed;
        r.want.status = st;
        r.want.head   = head;
        r.want.occ    = OCC_W'(occ);
        dir_rows.push_back(r);
    endtask

    // Offer one transaction, starting at a falling edge; hold it until accepted.
    // Returns at the falling edge after acceptance with in_valid still high.
    task automatic send_item(input action_t act, input logic [IO_TAG_W-1:0] tag,
                             input bit typed, input qres_t want);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        item_tag  <= tag;
        row_typed = typed;
        row_want  = want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random transaction with weighted actions; removes mostly aim at held tags.
    task automatic send_random(input int w_enq, input int w_deq, input int w_rem,
                               input int w_clr);
        int                  r;
        action_t             act;
        logic [IO_TAG_W-1:0] tag;
        r = $urandom_range(0, w_enq + w_deq + w_rem + w_clr - 1);
        if (r < w_enq)
            act = ACT_ENQUEUE;
        else if (r < w_enq + w_deq)
            act = ACT_DEQUEUE;
        else if (r < w_enq + w_deq + w_rem)
            act = ACT_REMOVE;
        else
            act = ACT_CLEAR;
        // Small pool values make duplicates, so remove has to find the first one.
        if ($urandom_range(0, 1) == 0)
            tag = $urandom();
        else
            tag = IO_TAG_W'($urandom_range(0, 7));
        if (act == ACT_REMOVE && held_tags.size() > 0 && $urandom_range(0, 9) < 7)
            tag = held_tags[$urandom_range(0, held_tags.size() - 1)];
        send_item(act, tag, 1'b0, '0);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
        @(negedge clk);
    endtask

    // Write the enable register while the block is idle.
    task automatic write_enable(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial begin : stimulus
        int i;
        int p;
        int n;
        int wts[4][4];

        // Disabled queue refuses everything.
        add_row(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b1, ST_NOT_INIT, '0, 0);
        add_row(ACT_DEQUEUE, 32'h0000_0000, 1'b1, ST_NOT_INIT, '0, 0);
        add_row(ACT_CLEAR,   32'hA5A5_A5A5, 1'b1, ST_NOT_INIT, '0, 0);
        // Empty queue: dequeue reports empty, remove finds nothing.
        add_row(ACT_DEQUEUE, 32'h0000_0000, 1'b1, ST_EMPTY,    '0, 0);
        add_row(ACT_REMOVE,  32'h0000_0000, 1'b1, ST_NO_ITEM,  '0, 0);
        // Fill to the brim with extreme and duplicate tags.
        add_row(ACT_ENQUEUE, 32'h0000_0000, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h1234_5678, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'hA5A5_A5A5, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h5A5A_5A5A, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h1234_5678, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h8000_0000, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h0000_0001, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h7FFF_FFFF, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'hFFFF_FFFE, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h0000_FFFF, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'hFFFF_0000, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h1357_9BDF, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h2468_ACE0, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'h5555_5555, 1'b0, ST_OK, '0, 0);
        add_row(ACT_ENQUEUE, 32'hAAAA_AAAA, 1'b0, ST_OK, '0, 0);
        // Full store drops the tag.
        add_row(ACT_ENQUEUE, 32'hC0FF_EE00, 1'b1, ST_FULL,    '0, DEPTH);
        // Duplicate tag: only the first copy leaves, the gap closes; then a missed remove, a dequeue, a clear.
        add_row(ACT_REMOVE,  32'h1234_5678, 1'b0, ST_OK,      '0, 0);
        add_row(ACT_REMOVE,  32'h0BAD_C0DE, 1'b1, ST_NO_ITEM, '0, DEPTH - 1);
        add_row(ACT_DEQUEUE, 32'hFFFF_FFFF, 1'b1, ST_OK,      32'h0000_0000, DEPTH - 2);
        add_row(ACT_CLEAR,   32'hFFFF_FFFF, 1'b1, ST_OK,      '0, 0);

        // Weights enqueue/dequeue/remove/clear: fill-heavy, drain-heavy, remove-heavy, mixed.
        wts = '{'{8, 2, 2, 1}, '{2, 8, 3, 1}, '{5, 1, 6, 1}, '{4, 3, 3, 1}};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: disabled rows, then enable and walk the rest.
        write_enable(1'b0);
        for (i = 0; i < dir_rows.size(); i++) begin
            if (i == OFF_ROWS) begin
                drain();
                write_enable(1'b1);
            end
            send_item(dir_rows[i].act, dir_rows[i].tag, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random traffic, balanced, with idling on both sides.
        for (i = 0; i < 100; i++)
            send_random(wts[3][0], wts[3][1], wts[3][2], wts[3][3]);

        // Receiver holds off while the sender keeps offering mostly enqueues back to back.
        gap_pct       = 0;
        long_hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_random(8, 1, 1, 0);
        // Sender pauses until every result is back.
        drain();
        gap_pct = 25;

        // Disabled with entries held: all refused, contents must survive.
        write_enable(1'b0);
        for (i = 0; i < 30; i++)
            send_random(1, 1, 1, 1);
        drain();
        write_enable(1'b1);

        // Biased sub-phases; the mixed one runs without any idling.
        for (p = 0; p < 4; p++) begin
            gap_pct   = (p == 3) ? 0 : $urandom_range(10, 50);
            stall_pct = (p == 3) ? 0 : $urandom_range(10, 50);
            for (n = 0; n < 50; n++)
                send_random(wts[p][0], wts[p][1], wts[p][2], wts[p][3]);
        end
        gap_pct   = 25;
        stall_pct = 25;

        // Last stretch at full rate on both sides.
        idle_on = 1'b0;
        for (i = 0; i < 70; i++)
            send_random(wts[p % 4][0], 3, 4, 1);

        drain();
        repeat (5) @(posedge clk);

        $display("Covered %0d transactions, %0d results checked, %0d input stall cycles.",
                 accepted_count, checked_count, full_stalls);
        $display("Statuses: ok %0d, not-init %0d, empty %0d, no-item %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_NOT_INIT], status_seen[ST_EMPTY],
                 status_seen[ST_NO_ITEM], status_seen[ST_FULL]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[fifo_queue_with_cancel] OK");
        end
        else begin
            $display("[fifo_queue_with_cancel] ERROR");
        end
        $finish;
    end

endmodule

### fifo_queue_with_cancel.f
hw/rtl/fq_pkg.sv
hw/rtl/fq_cell.sv
hw/rtl/fifo_queue_with_cancel.sv
verif/tb_fifo_queue_with_cancel.sv
